@@ src/eaac_pkg.sv @@
// Package for the extended-attribute area checker.
// Holds the length width, header constants and the byte item type.
// No dependencies.
package eaac_pkg;

  localparam int LENGTH_BITS  = 32;
  localparam int HEADER_BYTES = 7;
  localparam int MAX_PAD      = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

endpackage

@@ src/eaac_if.sv @@
// Channel interfaces for the extended-attribute area checker.
// eaac_in_if carries area bytes, eaac_out_if carries verdicts.
// No dependencies.
interface eaac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eaac_out_if;
  logic valid;
  logic ready;
  logic area_corrupt;

  modport source (output valid, output area_corrupt, input ready);
  modport sink   (input valid, input area_corrupt, output ready);
endinterface

@@ src/eaac_in_stage.sv @@
// Input register of the extended-attribute area checker.
// Registers one byte item from the input channel; uses eaac_pkg and eaac_in_if.
module eaac_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  eaac_in_if.sink             in_chan,
  input  logic                item_take,
  output logic                item_valid,
  output eaac_pkg::byte_item_t item
);
  import eaac_pkg::*;

  logic       valid_r, valid_nxt;
  byte_item_t item_r;

  assign in_chan.ready = !valid_r || item_take;
  assign item_valid    = valid_r;
  assign item          = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_chan.ready) begin
      valid_nxt = in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      item_r.data_byte <= in_chan.data_byte;
      item_r.last_byte <= in_chan.last_byte;
    end
  end
endmodule

@@ src/eaac_core.sv @@
// Entry tracking and checks of the extended-attribute area checker.
// Holds offset, entry length and sticky error; uses eaac_pkg.
module eaac_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  eaac_pkg::byte_item_t item,
  input  logic                 res_ready,
  output logic                 item_take,
  output logic                 res_load,
  output logic                 res_corrupt
);
  import eaac_pkg::*;

  logic [LENGTH_BITS-1:0] off_r, off_nxt;
  logic [31:0]            len_r, len_nxt;
  logic                   err_r, err_nxt;

  logic [LENGTH_BITS:0]   off_p1;
  logic [31:0]            full_len;
  logic [31:0]            name_end;
  logic                   fail;
  logic                   done;
  logic                   verdict;

  assign item_take   = item_valid && (!item.last_byte || res_ready);
  assign res_load    = item_take && item.last_byte;
  assign res_corrupt = verdict;

  assign off_p1   = {1'b0, off_r} + (LENGTH_BITS + 1)'(1);
  assign full_len = {item.data_byte, len_r[23:0]};
  assign name_end = {24'd0, item.data_byte} + 32'(HEADER_BYTES);

  always_comb begin
    off_nxt = off_r;
    len_nxt = len_r;
    fail    = err_r;
    done    = 1'b0;
    if (!err_r) begin
      if (off_r < LENGTH_BITS'(3)) begin
        len_nxt[8*off_r[1:0] +: 8] = item.data_byte;
      end else if (off_r == LENGTH_BITS'(3)) begin
        if (((full_len >> LENGTH_BITS) != 32'd0) || (full_len < 32'(HEADER_BYTES))) begin
          fail = 1'b1;
        end else begin
          len_nxt = full_len;
        end
      end else if (off_r == LENGTH_BITS'(5)) begin
        fail = (item.data_byte >= 8'(MAX_PAD));
      end else if (off_r == LENGTH_BITS'(6)) begin
        fail = (name_end > len_r);
      end
      done = !fail && (off_r >= LENGTH_BITS'(HEADER_BYTES - 1))
             && (32'(off_p1[LENGTH_BITS-1:0]) == len_r)
             && !off_p1[LENGTH_BITS];
      if (!fail) begin
        if (done) begin
          off_nxt = '0;
          len_nxt = '0;
        end else begin
          if (item.last_byte) begin
            fail = 1'b1;
          end
          off_nxt = off_p1[LENGTH_BITS-1:0];
        end
      end
    end
    verdict = fail;
    err_nxt = fail;
    if (item.last_byte) begin
      off_nxt = '0;
      len_nxt = '0;
      err_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
      len_r <= '0;
      err_r <= 1'b0;
    end else if (item_take) begin
      off_r <= off_nxt;
      len_r <= len_nxt;
      err_r <= err_nxt;
    end
  end
endmodule

@@ src/eaac_out_stage.sv @@
// Result register of the extended-attribute area checker.
// Holds one verdict for the output channel; uses eaac_out_if.
module eaac_out_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_load,
  input  logic       res_corrupt,
  output logic       res_ready,
  eaac_out_if.source out_chan
);
  logic valid_r, valid_nxt;
  logic corrupt_r;

  assign res_ready             = !valid_r || out_chan.ready;
  assign out_chan.valid        = valid_r;
  assign out_chan.area_corrupt = corrupt_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_load) begin
      corrupt_r <= res_corrupt;
    end
  end
endmodule

@@ src/ext_attr_area_checker.sv @@
// Extended-attribute area checker, top level.
// The verdict is loaded into the result register when the core takes the last byte.
// Throughput: one byte per cycle; input register, check logic, result register.
// A stalled result holds only a final byte; other bytes keep flowing.
// Reset (rst_n low, synchronous) clears offset, entry length, error and valids.
// Uses eaac_pkg, eaac_if, eaac_in_stage, eaac_core and eaac_out_stage.
module ext_attr_area_checker (
  input  logic       clk,
  input  logic       rst_n,
  eaac_in_if.sink    in_chan,
  eaac_out_if.source out_chan
);
  import eaac_pkg::*;

  logic       item_valid;
  byte_item_t item;
  logic       item_take;
  logic       res_load;
  logic       res_corrupt;
  logic       res_ready;

  eaac_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  eaac_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item        (item),
    .res_ready   (res_ready),
    .item_take   (item_take),
    .res_load    (res_load),
    .res_corrupt (res_corrupt)
  );

  eaac_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_load    (res_load),
    .res_corrupt (res_corrupt),
    .res_ready   (res_ready),
    .out_chan    (out_chan)
  );
endmodule

@@ tb/tb_ext_attr_area_checker.sv @@
`timescale 1ns / 100ps
// Testbench for ext_attr_area_checker: streams attribute areas byte by byte and
// checks each pass/corrupt verdict against an in-bench area predictor.
// Depends on eaac_pkg, eaac_if and the ext_attr_area_checker RTL.
module tb_ext_attr_area_checker;
  import eaac_pkg::*;

  typedef struct packed {
    byte_item_t item;
    logic       drain_first;
  } pend_t;

  localparam logic [63:0] LEN_MASK = (64'd1 << LENGTH_BITS) - 64'd1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  eaac_in_if  in_chan ();
  eaac_out_if out_chan ();

  ext_attr_area_checker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  pend_t      byte_queue[$];
  logic       expected_verdicts[$];
  logic [7:0] area_q[$];
  int         entry_starts[$];

  byte_item_t  cur_item;
  logic [31:0] entry_ofs;
  logic [31:0] entry_len;
  logic        area_err;
  int          in_gap;
  int          in_burst;
  int          out_stall;
  int          out_burst;
  int          mismatch_count;
  int          random_items;
  int          random_areas;
  logic        verdict;
  logic        want;

  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic check_area_byte(input logic [7:0] b, input logic last,
                                           output logic corrupt);
    logic [63:0] full;
    logic        done;
    done = 1'b0;
    if (!area_err) begin
      if (entry_ofs < 3) begin
        entry_len = entry_len | (32'(b) << (8 * entry_ofs));
      end else if (entry_ofs == 3) begin
        full = {32'd0, entry_len} | (64'(b) << 24);
        if (full > LEN_MASK || full < 64'(HEADER_BYTES)) area_err = 1'b1;
        else entry_len = full[31:0];
      end else if (entry_ofs == 5) begin
        if (32'(b) >= 32'(MAX_PAD)) area_err = 1'b1;
      end else if (entry_ofs == 6) begin
        if (64'(HEADER_BYTES) + 64'(b) > 64'(entry_len)) area_err = 1'b1;
      end
      if (!area_err && entry_ofs >= 32'(HEADER_BYTES - 1) &&
          64'(entry_ofs) + 64'd1 == 64'(entry_len))
        done = 1'b1;
      if (!area_err) begin
        if (done) begin
          entry_ofs = '0;
          entry_len = '0;
        end else begin
          if (last) area_err = 1'b1;
          full = (64'(entry_ofs) + 64'd1) & LEN_MASK;
          entry_ofs = full[31:0];
        end
      end
    end
    corrupt = area_err;
    if (last) begin
      entry_ofs = '0;
      entry_len = '0;
      area_err = 1'b0;
    end
    return last;
  endfunction

  task automatic queue_area(input bit drain);
    pend_t p;
    int    i;
    for (i = 0; i < area_q.size(); i++) begin
      p.item.data_byte = area_q[i];
      p.item.last_byte = (i == area_q.size() - 1);
      p.drain_first = drain && (i == 0);
      byte_queue.push_back(p);
    end
  endtask

  task automatic build_random_area();
    int mode, n_ent, len, nl, s, k, i;
    area_q.delete();
    entry_starts.delete();
    mode = $urandom_range(0, 99);
    if (mode < 5) begin
      k = $urandom_range(1, 16);
      for (i = 0; i < k; i++) area_q.push_back(8'($urandom));
      return;
    end
    n_ent = $urandom_range(1, 3);
    repeat (n_ent) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(7, 14);
      nl = $urandom_range(0, len - HEADER_BYTES);
      entry_starts.push_back(area_q.size());
      area_q.push_back(8'(len));
      area_q.push_back(8'd0);
      area_q.push_back(8'd0);
      area_q.push_back(8'd0);
      area_q.push_back(8'($urandom));
      area_q.push_back(8'($urandom_range(0, MAX_PAD - 1)));
      area_q.push_back(8'(nl));
      for (i = 0; i < len - HEADER_BYTES; i++) area_q.push_back(8'($urandom));
    end
    if (mode < 60) return;
    s = entry_starts[$urandom_range(0, entry_starts.size() - 1)];
    case ($urandom_range(0, 6))
      0: begin
        area_q[s] = 8'($urandom_range(0, HEADER_BYTES - 1));
      end
      1: begin
        area_q[s + 5] = 8'($urandom_range(MAX_PAD, 255));
      end
      2: begin
        area_q[s + 6] = 8'($urandom_range(area_q[s] - HEADER_BYTES + 1, 255));
      end
      3: begin
        k = $urandom_range(1, (area_q.size() - 1 < 8) ? area_q.size() - 1 : 8);
        repeat (k) void'(area_q.pop_back());
      end
      4: begin
        k = $urandom_range(1, 10);
        for (i = 0; i < k; i++) area_q.push_back(8'($urandom));
      end
      5: begin
        area_q[s + $urandom_range(1, 3)] = 8'($urandom_range(1, 255));
      end
      default: begin
        area_q[s + $urandom_range(0, area_q.size() - s - 1)] = 8'($urandom);
      end
    endcase
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.data_byte = 8'd0;
    in_chan.last_byte = 1'b0;
    out_chan.ready = 1'b0;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        if (check_area_byte(cur_item.data_byte, cur_item.last_byte, verdict))
          expected_verdicts.push_back(verdict);
        in_gap = pick_gap(in_burst);
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_chan.valid <= 1'b0;
        end else if (byte_queue.size() == 0) begin
          in_chan.valid <= 1'b0;
        end else if (byte_queue[0].drain_first && expected_verdicts.size() != 0) begin
          in_chan.valid <= 1'b0;
        end else begin
          cur_item = byte_queue.pop_front().item;
          in_chan.valid <= 1'b1;
          in_chan.data_byte <= cur_item.data_byte;
          in_chan.last_byte <= cur_item.last_byte;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("area_corrupt: no verdict expected, actual %0b", out_chan.area_corrupt);
          mismatch_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_chan.area_corrupt !== want) begin
            $error("area_corrupt mismatch: expected %0b actual %0b", want,
                   out_chan.area_corrupt);
            mismatch_count++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        out_stall = pick_gap(out_burst);
      end
    end
  end

  initial begin
    entry_ofs = '0;
    entry_len = '0;
    area_err = 1'b0;
    in_burst = 0;
    out_burst = 0;
    mismatch_count = 0;
    random_items = 0;
    random_areas = 0;

    area_q = '{8'hFF};
    queue_area(1'b0);
    area_q = '{8'h07, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h07, 8'h00};
    queue_area(1'b0);
    area_q = '{8'h00, 8'h00, 8'h00, 8'h00};
    queue_area(1'b0);
    area_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    queue_area(1'b0);
    area_q = '{8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08};
    queue_area(1'b0);

    while (random_items < 600) begin
      build_random_area();
      queue_area(random_areas == 0 || $urandom_range(0, 14) == 0);
      random_items += area_q.size();
      random_areas++;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() != 0 || in_chan.valid) @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_ext_attr_area_checker OK");
    end else begin
      $display("tb_ext_attr_area_checker NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_ext_attr_area_checker NOT OK");
    $finish;
  end

endmodule
